// ===== src/jvss_pkg.sv =====
package jvss_pkg;

  // Nesting limit and the width of the depth counter that follows from it
  localparam int unsigned MaxDepth = 255;
  localparam int unsigned DepthW   = $clog2(MaxDepth + 1);

  localparam int unsigned CmdW    = 2;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;

  // Commands
  localparam logic [CmdW-1:0] CmdSkip = 2'd0;
  localparam logic [CmdW-1:0] CmdExit = 2'd1;
  localparam logic [CmdW-1:0] CmdSeek = 2'd2;
  localparam logic [CmdW-1:0] CmdData = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] StDone     = 2'd0;
  localparam logic [StatusW-1:0] StEnded    = 2'd1;
  localparam logic [StatusW-1:0] StStream   = 2'd2;
  localparam logic [StatusW-1:0] StOverflow = 2'd3;

  // Structural characters
  localparam logic [ByteW-1:0] ChOpenCurly  = 8'h7B;
  localparam logic [ByteW-1:0] ChOpenSquare = 8'h5B;
  localparam logic [ByteW-1:0] ChCloseCurly = 8'h7D;
  localparam logic [ByteW-1:0] ChCloseSquare = 8'h5D;
  localparam logic [ByteW-1:0] ChQuote      = 8'h22;
  localparam logic [ByteW-1:0] ChBackslash  = 8'h5C;
  localparam logic [ByteW-1:0] ChComma      = 8'h2C;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [CountW-1:0] count;
    logic [ByteW-1:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic [StatusW-1:0] status;
  } res_t;

endpackage

// ===== src/jvss_if.sv =====
interface jvss_in_if;
  logic                         valid;
  logic                         ready;
  logic [jvss_pkg::CmdW-1:0]   command;
  logic [jvss_pkg::CountW-1:0] count;
  logic [jvss_pkg::ByteW-1:0]  data_byte;

  modport source (output valid, command, count, data_byte, input ready);
  modport sink   (input valid, command, count, data_byte, output ready);
endinterface

interface jvss_out_if;
  logic                          valid;
  logic                          ready;
  logic [jvss_pkg::StatusW-1:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

// ===== src/jvss_in_stage.sv =====
module jvss_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  jvss_pkg::item_t       in_item_i,
  output logic                  in_ready_o,
  input  logic                  adv_i,
  output logic                  valid_o,
  output jvss_pkg::item_t       item_o
);

  logic            valid_q, valid_d;
  jvss_pkg::item_t item_q;
  logic            load;

  // Stage takes a new item when empty or when its item moves on this cycle
  assign in_ready_o = !valid_q || adv_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/jvss_core.sv =====
module jvss_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  jvss_pkg::item_t item_i,
  output jvss_pkg::res_t  res_o
);

  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeSkip = 2'd1;
  localparam logic [1:0] ModeExit = 2'd2;
  localparam logic [1:0] ModeSeek = 2'd3;

  logic [1:0]                  mode_q, mode_d;
  logic [jvss_pkg::DepthW-1:0] depth_q, depth_d;
  logic [jvss_pkg::CountW-1:0] left_q, left_d;
  logic                        str_q, str_d;
  logic                        esc_q, esc_d;

  logic                         fin;
  logic [jvss_pkg::StatusW-1:0] fin_status;
  logic                         is_open, is_close;
  logic [jvss_pkg::CountW-1:0]  left_dec;

  assign is_open  = (item_i.data_byte == jvss_pkg::ChOpenCurly) ||
                    (item_i.data_byte == jvss_pkg::ChOpenSquare);
  assign is_close = (item_i.data_byte == jvss_pkg::ChCloseCurly) ||
                    (item_i.data_byte == jvss_pkg::ChCloseSquare);
  assign left_dec = left_q - 1'b1;

  always_comb begin
    mode_d     = mode_q;
    depth_d    = depth_q;
    left_d     = left_q;
    str_d      = str_q;
    esc_d      = esc_q;
    fin        = 1'b0;
    fin_status = jvss_pkg::StDone;

    if (item_i.command != jvss_pkg::CmdData) begin
      // any start abandons the running search
      depth_d = '0;
      left_d  = '0;
      str_d   = 1'b0;
      esc_d   = 1'b0;
      if (item_i.command == jvss_pkg::CmdSeek) begin
        mode_d = ModeSeek;
      end else if (item_i.count == '0) begin
        fin = 1'b1;
      end else begin
        mode_d = (item_i.command == jvss_pkg::CmdSkip) ? ModeSkip : ModeExit;
        left_d = item_i.count;
      end
    end else if (mode_q == ModeIdle) begin
      // data while idle is dropped
    end else if (item_i.data_byte == '0) begin
      fin        = 1'b1;
      fin_status = jvss_pkg::StStream;
    end else if (str_q) begin
      if (esc_q) begin
        esc_d = 1'b0;
      end else if (item_i.data_byte == jvss_pkg::ChBackslash) begin
        esc_d = 1'b1;
      end else if (item_i.data_byte == jvss_pkg::ChQuote) begin
        str_d = 1'b0;
      end
    end else if (mode_q == ModeSeek) begin
      if (is_open) begin
        mode_d  = ModeExit;
        left_d  = jvss_pkg::CountW'(1);
        depth_d = '0;
      end
    end else if (item_i.data_byte == jvss_pkg::ChQuote) begin
      str_d = 1'b1;
      esc_d = 1'b0;
    end else if (is_open) begin
      if (depth_q >= jvss_pkg::DepthW'(jvss_pkg::MaxDepth)) begin
        fin        = 1'b1;
        fin_status = jvss_pkg::StOverflow;
      end else begin
        depth_d = depth_q + 1'b1;
      end
    end else if (is_close) begin
      if (depth_q != '0) begin
        depth_d = depth_q - 1'b1;
      end else if (mode_q == ModeSkip) begin
        fin        = 1'b1;
        fin_status = jvss_pkg::StEnded;
      end else begin
        left_d = left_dec;
        fin    = (left_dec == '0);
      end
    end else if (item_i.data_byte == jvss_pkg::ChComma && mode_q == ModeSkip &&
                 depth_q == '0) begin
      left_d = left_dec;
      fin    = (left_dec == '0);
    end

    if (fin) begin
      mode_d  = ModeIdle;
      depth_d = '0;
      left_d  = '0;
      str_d   = 1'b0;
      esc_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      depth_q <= '0;
      left_q  <= '0;
      str_q   <= 1'b0;
      esc_q   <= 1'b0;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      left_q  <= left_d;
      str_q   <= str_d;
      esc_q   <= esc_d;
    end
  end

  assign res_o.valid  = adv_i && fin;
  assign res_o.status = fin_status;

endmodule

// ===== src/jvss_out_reg.sv =====
module jvss_out_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  jvss_pkg::res_t               res_i,
  output logic                         free_o,
  output logic                         out_valid_o,
  output logic [jvss_pkg::StatusW-1:0] out_status_o,
  input  logic                         out_ready_i
);

  logic                         valid_q, valid_d;
  logic [jvss_pkg::StatusW-1:0] status_q;

  // Free when empty or the held result is taken this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      status_q <= res_i.status;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_status_o = status_q;

endmodule

// ===== src/json_value_skip_scanner.sv =====
// Channel | Dir | Payload                       | Handshake
// in_i    | in  | command, count, data_byte     | valid / ready
// out_o   | out | status                        | valid / ready
//
// One item per cycle sustained while the result register is free. An accepted
// item is held in the input register; the scan state update and the status
// decision are made combinationally from it and land in the result register
// when the item advances, from which the status is offered. Reset clears the
// scan state to idle and both stages to empty. A stalled result holds the pipe
// only once the input stage is also full.
module json_value_skip_scanner (
  input logic        clk_i,
  input logic        rst_ni,
  jvss_in_if.sink    in_i,
  jvss_out_if.source out_o
);

  jvss_pkg::item_t in_item;
  jvss_pkg::item_t stage_item;
  jvss_pkg::res_t  res;
  logic            stage_valid;
  logic            out_free;
  logic            adv;

  assign in_item.command   = in_i.command;
  assign in_item.count     = in_i.count;
  assign in_item.data_byte = in_i.data_byte;

  assign adv = stage_valid && out_free;

  jvss_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_item_i  (in_item),
    .in_ready_o (in_i.ready),
    .adv_i      (adv),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  jvss_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (stage_item),
    .res_o  (res)
  );

  jvss_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .free_o       (out_free),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_ready_i  (out_o.ready)
  );

endmodule

// ===== src/jvss_checker.sv =====
module jvss_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [jvss_pkg::StatusW-1:0] out_status_i
);

  logic        in_xfer, out_xfer;
  logic [31:0] owed_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // items accepted minus results delivered so far
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else begin
      owed_q <= owed_q + 32'(in_xfer) - 32'(out_xfer);
    end
  end

  a_no_result_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("stalled result changed");

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> owed_q != '0)
    else $error("more results than accepted items");

  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a held result");

endmodule

bind json_value_skip_scanner jvss_checker u_jvss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import jvss_pkg::*;

  typedef enum logic [1:0] {ModeIdle, ModeSkip, ModeExit, ModeSeek} scan_mode_e;

  typedef struct {
    item_t              it;
    bit                 typed;    // expectation written into the row
    bit                 has_res;
    logic [StatusW-1:0] status;
  } dir_row_t;

  localparam int unsigned HoldOffCycles = 300;

  logic clk_i;
  logic rst_ni;

  jvss_in_if  in_if ();
  jvss_out_if out_if ();

  json_value_skip_scanner u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Scanner state as predicted
  scan_mode_e         scan_mode = ModeIdle;
  logic [DepthW-1:0]  nest_depth = '0;
  logic [CountW-1:0]  remaining = '0;
  logic               in_string = 1'b0;
  logic               escaped = 1'b0;

  logic [StatusW-1:0] pending_status[$];
  dir_row_t           directed_rows[$];
  int                 mismatches = 0;
  int                 burst_left = 0;
  int                 sent_items = 0;
  bit                 hold_off_req = 1'b0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic item_t mk_item(input logic [CmdW-1:0] cmd, input logic [CountW-1:0] cnt,
                                    input logic [ByteW-1:0] b);
    item_t it;
    it.command   = cmd;
    it.count     = cnt;
    it.data_byte = b;
    return it;
  endfunction

  function automatic void clear_nesting();
    nest_depth = '0;
    remaining  = '0;
    in_string  = 1'b0;
    escaped    = 1'b0;
  endfunction

  // Advances the predicted state by one item; returns 1 when a status is due
  function automatic bit scan_step(input item_t it, output logic [StatusW-1:0] st);
    bit               fin;
    bit               opener;
    bit               closer;
    logic [ByteW-1:0] b;
    fin    = 1'b0;
    st     = StDone;
    b      = it.data_byte;
    opener = (b == ChOpenCurly) || (b == ChOpenSquare);
    closer = (b == ChCloseCurly) || (b == ChCloseSquare);
    if (it.command != CmdData) begin
      // any start drops a running search silently
      clear_nesting();
      if (it.command == CmdSeek) begin
        scan_mode = ModeSeek;
      end else if (it.count == '0) begin
        fin = 1'b1;
      end else begin
        scan_mode = (it.command == CmdSkip) ? ModeSkip : ModeExit;
        remaining = it.count;
      end
    end else if (scan_mode == ModeIdle) begin
      fin = 1'b0;
    end else if (b == '0) begin
      fin = 1'b1;
      st  = StStream;
    end else if (in_string) begin
      if (escaped) escaped = 1'b0;
      else if (b == ChBackslash) escaped = 1'b1;
      else if (b == ChQuote) in_string = 1'b0;
    end else if (scan_mode == ModeSeek) begin
      if (opener) begin
        scan_mode  = ModeExit;
        remaining  = CountW'(1);
        nest_depth = '0;
      end
    end else if (b == ChQuote) begin
      in_string = 1'b1;
      escaped   = 1'b0;
    end else if (opener) begin
      if (nest_depth >= MaxDepth) begin
        fin = 1'b1;
        st  = StOverflow;
      end else begin
        nest_depth = nest_depth + 1'b1;
      end
    end else if (closer) begin
      if (nest_depth != '0) begin
        nest_depth = nest_depth - 1'b1;
      end else if (scan_mode == ModeSkip) begin
        fin = 1'b1;
        st  = StEnded;
      end else begin
        remaining = remaining - 1'b1;
        fin = (remaining == '0);
      end
    end else if (b == ChComma && scan_mode == ModeSkip && nest_depth == '0) begin
      remaining = remaining - 1'b1;
      fin = (remaining == '0);
    end
    if (fin) begin
      scan_mode = ModeIdle;
      clear_nesting();
    end
    return fin;
  endfunction

  function automatic void add_row(input logic [CmdW-1:0] cmd, input logic [CountW-1:0] cnt,
                                  input logic [ByteW-1:0] b, input bit typed = 1'b0,
                                  input bit has_res = 1'b0,
                                  input logic [StatusW-1:0] status = StDone);
    dir_row_t row;
    row.it      = mk_item(cmd, cnt, b);
    row.typed   = typed;
    row.has_res = has_res;
    row.status  = status;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Mostly structural bytes so that searches get somewhere
  function automatic logic [ByteW-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) return $urandom_range(0, 1) ? ChOpenCurly : ChOpenSquare;
    if (r < 28) return $urandom_range(0, 1) ? ChCloseCurly : ChCloseSquare;
    if (r < 43) return ChComma;
    if (r < 54) return ChQuote;
    if (r < 60) return ChBackslash;
    if (r < 62) return '0;
    return ByteW'($urandom_range(1, 255));
  endfunction

  // Sender side: bursts with random gaps, one transfer per call
  task automatic offer(input item_t it, input bit typed = 1'b0, input bit t_has = 1'b0,
                       input logic [StatusW-1:0] t_status = StDone);
    int                 gap;
    bit                 hit;
    logic [StatusW-1:0] st;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.command   <= it.command;
    in_if.count     <= it.count;
    in_if.data_byte <= it.data_byte;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    sent_items++;
    hit = scan_step(it, st);
    if (typed) begin
      hit = t_has;
      st  = t_status;
    end
    if (hit) pending_status.insert(pending_status.size(), st);
  endtask

  // Wait until every predicted status has come back, then idle a while
  task automatic settle(input int extra);
    in_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Result checker; handshake sampled mid-cycle, the transfer is the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_status.size() == 0) begin
        if (mismatches < 10) $display("unexpected status %0d, nothing pending", out_if.status);
        mismatches++;
      end else if (out_if.status !== pending_status[0]) begin
        if (mismatches < 10)
          $display("status mismatch: expected %0d, got %0d", pending_status[0], out_if.status);
        mismatches++;
        void'(pending_status.pop_front());
      end else begin
        void'(pending_status.pop_front());
      end
    end
  end

  // Receiver: stall patterns that change after a random span, plus a long hold-off
  initial begin
    int span;
    int pat;
    int k;
    span = 0;
    pat  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        for (k = 0; k < HoldOffCycles; k++) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      if (span == 0) begin
        pat  = $urandom_range(0, 3);
        span = $urandom_range(10, 80);
      end
      span--;
      case (pat)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= (span % 3 != 0);
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("json_value_skip_scanner test failed");
    $finish;
  end

  initial begin
    int               seq_no;
    int               len;
    int               target;
    int               k;
    int               r;
    logic [CmdW-1:0]  cmd;
    logic [CountW-1:0] cnt;
    seq_no  = 0;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.command   <= CmdData;
    in_if.count     <= '0;
    in_if.data_byte <= '0;

    //       command  count      byte           typed  has   status
    add_row(CmdData, 16'd0,     ChOpenCurly,   1'b1,  1'b0);             // data while idle
    add_row(CmdSkip, 16'd0,     8'h00,         1'b1,  1'b1, StDone);     // zero count
    add_row(CmdExit, 16'd0,     8'hFF,         1'b1,  1'b1, StDone);
    add_row(CmdSkip, 16'hFFFF,  8'hFF);
    add_row(CmdData, 16'hFFFF,  ChCloseSquare, 1'b1,  1'b1, StEnded);    // close at top of skip
    add_row(CmdSkip, 16'd2,     8'h00);
    add_row(CmdData, 16'd0,     ChComma);
    add_row(CmdData, 16'd0,     ChQuote);
    add_row(CmdData, 16'd0,     ChBackslash);
    add_row(CmdData, 16'd0,     ChQuote);                                // escaped quote
    add_row(CmdData, 16'd0,     ChComma);                                // comma in string
    add_row(CmdData, 16'd0,     ChQuote);
    add_row(CmdData, 16'd0,     ChOpenSquare);
    add_row(CmdData, 16'd0,     ChComma);                                // nested comma
    add_row(CmdData, 16'd0,     ChCloseCurly);                           // mismatched close
    add_row(CmdData, 16'd0,     ChComma);
    add_row(CmdExit, 16'd1,     8'h00);
    add_row(CmdData, 16'd0,     ChOpenCurly);
    add_row(CmdData, 16'd0,     8'hFF);
    add_row(CmdSeek, 16'hFFFF,  8'h00,         1'b1,  1'b0);             // start while busy
    add_row(CmdData, 16'd0,     ChCloseSquare);                          // ignored while seeking
    add_row(CmdData, 16'd0,     ChOpenSquare);
    add_row(CmdData, 16'd0,     ChQuote);
    add_row(CmdData, 16'd0,     ChBackslash);
    add_row(CmdData, 16'd0,     8'h00,         1'b1,  1'b1, StStream);   // zero after backslash
    add_row(CmdExit, 16'd1,     8'h00);
    add_row(CmdData, 16'd0,     ChCloseCurly,  1'b1,  1'b1, StDone);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].has_res,
            directed_rows[i].status);
    settle($urandom_range(5, 30));

    while (sent_items < 900) begin
      seq_no++;

      if (seq_no == 12) begin
        // receiver holds off while zero-count starts keep producing statuses
        hold_off_req = 1'b1;
        repeat (24) offer(mk_item(CmdSkip, 16'd0, ByteW'($urandom_range(0, 255))));
        settle($urandom_range(5, 30));
      end

      if (seq_no == 3) begin
        // nest close to or past the depth limit
        offer(mk_item($urandom_range(0, 1) ? CmdExit : CmdSkip,
                      CountW'($urandom_range(1, 3)), ByteW'($urandom_range(0, 255))));
        target = $urandom_range(MaxDepth - 5, MaxDepth + 3);
        for (k = 0; k < target && scan_mode != ModeIdle; k++)
          offer(mk_item(CmdData, CountW'($urandom_range(0, 65535)),
                        $urandom_range(0, 1) ? ChOpenCurly : ChOpenSquare));
        for (k = 0; k < 2 * MaxDepth && scan_mode != ModeIdle; k++)
          offer(mk_item(CmdData, CountW'($urandom_range(0, 65535)),
                        $urandom_range(0, 1) ? ChCloseCurly : ChCloseSquare));
      end

      case ($urandom_range(0, 2))
        0: cmd = CmdSkip;
        1: cmd = CmdExit;
        default: cmd = CmdSeek;
      endcase
      r = $urandom_range(0, 9);
      if (r < 7) cnt = CountW'($urandom_range(1, 4));
      else if (r < 9) cnt = CountW'($urandom_range(0, 16));
      else cnt = CountW'($urandom_range(0, 65535));
      offer(mk_item(cmd, cnt, ByteW'($urandom_range(0, 255))));

      len = $urandom_range(4, 50);
      for (k = 0; k < len && scan_mode != ModeIdle; k++)
        offer(mk_item(CmdData, CountW'($urandom_range(0, 65535)), pick_byte()));

      // stray bytes between searches
      if (scan_mode == ModeIdle && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 2))
          offer(mk_item(CmdData, CountW'($urandom_range(0, 65535)),
                        ByteW'($urandom_range(0, 255))));

      if (seq_no == 30 || $urandom_range(0, 19) == 0)
        settle($urandom_range(1, 20));
    end

    settle(20);
    if (mismatches == 0) begin
      $display("json_value_skip_scanner test passed");
    end else begin
      $display("json_value_skip_scanner test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/jvss_pkg.sv
src/jvss_if.sv
src/jvss_in_stage.sv
src/jvss_core.sv
src/jvss_out_reg.sv
src/json_value_skip_scanner.sv
src/jvss_checker.sv
dv/tb.sv
